// ----- design/bit_signature_scanner_assert.svh -----
// Assertion macros for the bit signature scanner.
// Each macro checks on the rising edge of aclk and is off while aresetn is low.
`ifndef BIT_SIGNATURE_SCANNER_ASSERT_SVH
`define BIT_SIGNATURE_SCANNER_ASSERT_SVH

`ifndef SYNTHESIS
`define BSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSS_ASSERT(lbl, prop, msg)
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/bss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

    localparam int ENTRY_W = 4;
    localparam int PAT_W   = 64;
    localparam int LEN_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 5;
    localparam int CMD_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EOF   = 2'd3;

    // Control broadcast from the sequencer to every signature cell.
    typedef struct packed {
        logic               clear;
        logic               write;
        logic               check;
        logic [ENTRY_W-1:0] wr_index;
        logic [LEN_W-1:0]   wr_length;
        logic               wr_never;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/bit_signature_scanner.sv -----
// File byte: accepted, then shifted one bit per cycle, and the next request is taken on
// the last shifted bit; all cells compare in parallel on each shifted bit.
// End of file: the count walks the cell chain one cell per cycle, registered in each
// cell; input is held off until it leaves the last cell, then the result is registered.
// Synchronous active-low reset clears the valid bits, found flags, window, sequencer and
// output valid flag; patterns are not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "bit_signature_scanner_assert.svh"

module bit_signature_scanner #(
    parameter int NUM_SIGS     = 16,
    parameter int MAX_SIG_BITS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] entry_index, [67:4] pattern_bits, [74:68] pattern_length,
    // [75] never_match, [83:76] data_byte, [87:84] zero
    input  wire logic [87:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [4:0] match_count, [5] any_match, [7:6] zero
    output logic [7:0]       m_tdata
);

    localparam int SEEN_W = $clog2(MAX_SIG_BITS + 1);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_COUNT = 2'd2;

    // Request fields.
    logic [bss_pkg::CMD_W-1:0]   command;
    logic [bss_pkg::ENTRY_W-1:0] entry_index;
    logic [bss_pkg::PAT_W-1:0]   pattern_bits;
    logic [bss_pkg::LEN_W-1:0]   pattern_length;
    logic                        never_match;
    logic [bss_pkg::BYTE_W-1:0]  data_byte;

    assign command        = s_tuser;
    assign entry_index    = s_tdata[3:0];
    assign pattern_bits   = s_tdata[67:4];
    assign pattern_length = s_tdata[74:68];
    assign never_match    = s_tdata[75];
    assign data_byte      = s_tdata[83:76];

    logic [1:0]                 state_reg, state_next;
    logic [2:0]                 bit_cnt_reg;
    logic [bss_pkg::BYTE_W-1:0] byte_reg;
    logic                       out_valid_reg;
    logic [bss_pkg::COUNT_W-1:0] out_count_reg;

    logic                       accept;
    logic                       last_bit;
    logic                       shift_en;
    logic                       eof_start;
    bss_pkg::cell_ctl_t         ctl;

    logic [MAX_SIG_BITS-1:0]    win_next;
    logic [SEEN_W-1:0]          seen_next;

    // Count chain: position 0 feeds the first cell, position NUM_SIGS leaves the last.
    logic [NUM_SIGS:0]          tok;
    logic [bss_pkg::COUNT_W-1:0] cnt [NUM_SIGS+1];
    logic                       tok_last;

    // The block takes a request when idle or on the last bit of a byte, so bytes
    // stream back to back. An end of file waits while an earlier result is unread,
    // since the output register has room for only one.
    assign last_bit = (state_reg == ST_SHIFT) && (bit_cnt_reg == 3'd7);
    assign s_tready = ((state_reg == ST_IDLE) || last_bit)
                   && !((command == bss_pkg::CMD_EOF) && out_valid_reg);
    assign accept   = s_tvalid && s_tready;
    assign shift_en = (state_reg == ST_SHIFT);
    assign eof_start = accept && (command == bss_pkg::CMD_EOF);
    assign tok_last  = tok[NUM_SIGS];

    always_comb begin
        ctl.clear     = accept && (command == bss_pkg::CMD_CLEAR);
        ctl.write     = accept && (command == bss_pkg::CMD_WRITE);
        ctl.check     = shift_en;
        ctl.wr_index  = entry_index;
        ctl.wr_length = pattern_length;
        ctl.wr_never  = never_match;
    end

    // Next state. A request taken on the last bit of a byte decides what follows.
    always_comb begin
        state_next = state_reg;
        if (accept) begin
            case (command)
                bss_pkg::CMD_BYTE: state_next = ST_SHIFT;
                bss_pkg::CMD_EOF:  state_next = ST_COUNT;
                default:           state_next = ST_IDLE;
            endcase
        end else begin
            case (state_reg)
                ST_SHIFT: if (last_bit) begin
                    state_next = ST_IDLE;
                end
                ST_COUNT: if (tok_last) begin
                    state_next = ST_IDLE;
                end
                default:  state_next = state_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && (command == bss_pkg::CMD_BYTE)) begin
                bit_cnt_reg <= 3'd0;
            end else if (shift_en) begin
                bit_cnt_reg <= bit_cnt_reg + 3'd1;
            end
            if (tok_last) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The byte register feeds its top bit into the window, most significant bit first.
    always_ff @(posedge aclk) begin
        if (accept && (command == bss_pkg::CMD_BYTE)) begin
            byte_reg <= data_byte;
        end else if (shift_en) begin
            byte_reg <= byte_reg << 1;
        end
        if (tok_last) begin
            out_count_reg <= cnt[NUM_SIGS];
        end
    end

    bss_window #(
        .MAX_SIG_BITS (MAX_SIG_BITS),
        .SEEN_W       (SEEN_W)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (shift_en),
        .bit_in    (byte_reg[bss_pkg::BYTE_W-1]),
        .clear     (eof_start),
        .win_next  (win_next),
        .seen_next (seen_next)
    );

    assign tok[0] = eof_start;
    assign cnt[0] = '0;

    // One cell per table entry. Each holds its signature and found flag and, during
    // an end of file, adds its flag to the running count and passes it on.
    for (genvar k = 0; k < NUM_SIGS; k++) begin : g_cell
        bss_cell #(
            .INDEX        (k),
            .MAX_SIG_BITS (MAX_SIG_BITS),
            .SEEN_W       (SEEN_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .wr_pattern (pattern_bits),
            .win_next   (win_next),
            .seen_next  (seen_next),
            .tok_in     (tok[k]),
            .cnt_in     (cnt[k]),
            .tok_out    (tok[k+1]),
            .cnt_out    (cnt[k+1])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, (out_count_reg != '0), out_count_reg};

    // Only one count walks the chain at a time.
    `BSS_ASSERT(a_one_token, $onehot0(tok[NUM_SIGS:1]), "more than one count in the cell chain")
    // A finished count never lands on an unread result.
    `BSS_ASSERT(a_no_overwrite, !tok_last || !out_valid_reg || m_tready,
        "count finished while result register was full")
    // The sequencer takes no request while a count is walking the chain.
    `BSS_ASSERT_NEXT(a_eof_blocks, eof_start, (state_reg == ST_COUNT) && !s_tready,
        "request taken during an end-of-file count")

endmodule

`default_nettype wire

// ----- design/bss_window.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bss_window #(
    parameter int MAX_SIG_BITS = 64,
    parameter int SEEN_W       = 7
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    shift_en,
    input  wire logic                    bit_in,
    input  wire logic                    clear,
    output logic [MAX_SIG_BITS-1:0]      win_next,
    output logic [SEEN_W-1:0]            seen_next
);

    logic [MAX_SIG_BITS-1:0] win_reg;
    logic [SEEN_W-1:0]       seen_reg;

    // The cells compare against the window as it stands after this bit.
    always_comb begin
        win_next  = win_reg;
        seen_next = seen_reg;
        if (shift_en) begin
            win_next = (win_reg << 1) | MAX_SIG_BITS'(bit_in);
            if (seen_reg != SEEN_W'(MAX_SIG_BITS)) begin
                seen_next = seen_reg + SEEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            win_reg  <= '0;
            seen_reg <= '0;
        end else begin
            win_reg  <= win_next;
            seen_reg <= seen_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/bss_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bss_cell #(
    parameter int INDEX        = 0,
    parameter int MAX_SIG_BITS = 64,
    parameter int SEEN_W       = 7
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bss_pkg::cell_ctl_t            ctl,
    input  wire logic [bss_pkg::PAT_W-1:0]     wr_pattern,
    input  wire logic [MAX_SIG_BITS-1:0]       win_next,
    input  wire logic [SEEN_W-1:0]             seen_next,
    input  wire logic                          tok_in,
    input  wire logic [bss_pkg::COUNT_W-1:0]   cnt_in,
    output logic                               tok_out,
    output logic [bss_pkg::COUNT_W-1:0]        cnt_out
);

    localparam logic [8:0] IDX = 9'(INDEX);

    logic [MAX_SIG_BITS-1:0]         pattern_reg;
    logic [bss_pkg::LEN_W-1:0]       len_reg;
    logic                            usable_reg;
    logic                            valid_reg;
    logic                            found_reg;
    logic                            tok_reg;
    logic [bss_pkg::COUNT_W-1:0]     cnt_reg;

    logic [MAX_SIG_BITS-1:0]         mask;
    logic                            write_hit;
    logic                            match;
    logic                            counted;

    assign write_hit = ctl.write && (9'(ctl.wr_index) == IDX);

    always_comb begin
        for (int i = 0; i < MAX_SIG_BITS; i++) begin
            mask[i] = len_reg > bss_pkg::LEN_W'(i);
        end
        match = valid_reg && usable_reg
             && (len_reg <= bss_pkg::LEN_W'(MAX_SIG_BITS))
             && (len_reg <= bss_pkg::LEN_W'(seen_next))
             && (((win_next ^ pattern_reg) & mask) == '0);
    end

    // An end of file taken on the last bit of a byte reaches the first cell in the same
    // cycle as that bit, so a match on that bit counts there as well.
    assign counted = valid_reg && (found_reg || (ctl.check && match))
                  && (cnt_in != bss_pkg::COUNT_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            found_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end else begin
            tok_reg <= tok_in;
            if (ctl.clear) begin
                valid_reg <= 1'b0;
                found_reg <= 1'b0;
            end else if (write_hit) begin
                valid_reg <= 1'b1;
                found_reg <= 1'b0;
            end else if (tok_in) begin
                found_reg <= 1'b0;
            end else if (ctl.check && match) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (write_hit) begin
            pattern_reg <= wr_pattern[MAX_SIG_BITS-1:0];
            len_reg     <= ctl.wr_length;
            usable_reg  <= !ctl.wr_never;
        end
        if (tok_in) begin
            cnt_reg <= counted ? cnt_in + bss_pkg::COUNT_W'(1) : cnt_in;
        end
    end

    assign tok_out = tok_reg;
    assign cnt_out = cnt_reg;

endmodule

`default_nettype wire
